// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the frame receiver.
// Depends on nothing; the user module must provide aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LFRC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("lfrc assertion failed");
`define LFRC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lfrc assertion failed");
`else
`define LFRC_ASSERT_ALWAYS(label, expr)
`define LFRC_ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

// ===== src/lfrc_pkg.sv =====
// Types, codes and the CRC-32 byte update for the link frame receiver.
// Depends on nothing; every other module file imports it.
package lfrc_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] CRC_TOP  = 32'h80000000;

    localparam logic [1:0] REG_FRAMING_MODE = 2'd0;
    localparam logic [1:0] REG_CHECK_MODE   = 2'd1;
    localparam logic [1:0] REG_FLAG_VALUE   = 2'd2;
    localparam logic [1:0] REG_ESCAPE_VALUE = 2'd3;

    localparam logic [1:0] CHK_NONE   = 2'd0;
    localparam logic [1:0] CHK_PARITY = 2'd1;
    localparam logic [1:0] CHK_CRC    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic       RESET_FRAMING = 1'b1;
    localparam logic [1:0] RESET_CHECK   = CHK_NONE;
    localparam logic [7:0] RESET_FLAG    = 8'd126;
    localparam logic [7:0] RESET_ESCAPE  = 8'd125;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } phase_t;

    typedef struct packed {
        logic       framing_mode;
        logic [1:0] check_mode;
        logic [7:0] flag_value;
        logic [7:0] escape_value;
    } cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_end;
        logic [1:0] frame_status;
    } result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 32'h0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/lfrc_cfg_regs.sv =====
// Configuration registers of the frame receiver with the frame clear strobe.
// Depends on lfrc_pkg.
module lfrc_cfg_regs
    import lfrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_t       cfg,
    output logic       frame_clear
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next    = cfg_reg;
        frame_clear = 1'b0;
        if (wr_en) begin
            case (wr_index)
                REG_FRAMING_MODE: begin
                    cfg_next.framing_mode = wr_data[0];
                    frame_clear           = 1'b1;
                end
                REG_CHECK_MODE: begin
                    cfg_next.check_mode = wr_data[1:0];
                    frame_clear         = 1'b1;
                end
                REG_FLAG_VALUE:   cfg_next.flag_value   = wr_data;
                REG_ESCAPE_VALUE: cfg_next.escape_value = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.framing_mode <= RESET_FRAMING;
            cfg_reg.check_mode   <= RESET_CHECK;
            cfg_reg.flag_value   <= RESET_FLAG;
            cfg_reg.escape_value <= RESET_ESCAPE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lfrc_deframer.sv =====
// Deframing state, trailer hold and running CRC/parity; one word per step.
// Depends on lfrc_pkg.
module lfrc_deframer
    import lfrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       frame_clear,
    input  logic       step_en,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  hold_reg [4];
    logic [7:0]  hold_next [4];
    logic [2:0]  fill_reg, fill_next;
    logic [31:0] crc_reg, crc_next;
    logic        par_reg, par_next;

    logic [2:0]  tlen;
    logic [1:0]  last_idx;
    logic [2:0]  fill_c;
    logic [31:0] crc_c;
    logic        par_c;
    logic        do_push;
    logic        frame_done;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [31:0] rx_crc;

    always_comb begin
        case (cfg.check_mode)
            CHK_PARITY: begin
                tlen     = 3'd1;
                last_idx = 2'd0;
            end
            CHK_CRC: begin
                tlen     = 3'd4;
                last_idx = 2'd3;
            end
            default: begin
                tlen     = 3'd0;
                last_idx = 2'd0;
            end
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        fill_c     = fill_reg;
        crc_c      = crc_reg;
        par_c      = par_reg;
        do_push    = 1'b0;
        frame_done = 1'b0;

        if (!cfg.framing_mode) begin
            if (phase_reg == PH_IDLE) begin
                fill_c = 3'd0;
                crc_c  = 32'h0;
                par_c  = 1'b0;
                if (rx_byte == 8'd0) begin
                    left_next  = 8'd0;
                    frame_done = 1'b1;
                end else begin
                    left_next  = rx_byte;
                    phase_next = PH_FRAME;
                end
            end else begin
                do_push   = 1'b1;
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0) begin
                    frame_done = 1'b1;
                end
            end
        end else begin
            if (phase_reg == PH_IDLE) begin
                if (rx_byte == cfg.flag_value) begin
                    fill_c     = 3'd0;
                    crc_c      = 32'h0;
                    par_c      = 1'b0;
                    left_next  = 8'd0;
                    phase_next = PH_FRAME;
                end
            end else if (phase_reg == PH_ESC) begin
                phase_next = PH_FRAME;
                do_push    = 1'b1;
            end else if (rx_byte == cfg.flag_value) begin
                // The flag test comes first, so a flag equal to the escape closes the frame.
                frame_done = 1'b1;
            end else if (rx_byte == cfg.escape_value) begin
                phase_next = PH_ESC;
            end else begin
                do_push = 1'b1;
            end
        end
    end

    // Push into the trailer hold; a word leaves the hold once it is full, or bypasses it with no trailer check.
    always_comb begin
        hold_next = hold_reg;
        fill_next = fill_c;
        crc_next  = crc_c;
        par_next  = par_c;
        out_valid = 1'b0;
        out_byte  = 8'd0;
        if (do_push) begin
            if (tlen == 3'd0) begin
                out_valid = 1'b1;
                out_byte  = rx_byte;
            end else if (fill_c < tlen) begin
                hold_next[fill_c[1:0]] = rx_byte;
                fill_next              = fill_c + 3'd1;
            end else begin
                out_valid = 1'b1;
                out_byte  = hold_reg[0];
                if (tlen == 3'd4) begin
                    hold_next[0] = hold_reg[1];
                    hold_next[1] = hold_reg[2];
                    hold_next[2] = hold_reg[3];
                end
                hold_next[last_idx] = rx_byte;
            end
            if (out_valid) begin
                crc_next = crc32_byte(crc_c, out_byte);
                par_next = par_c ^ (^out_byte);
            end
        end
    end

    assign rx_crc = {hold_next[0], hold_next[1], hold_next[2], hold_next[3]};

    always_comb begin
        if (fill_next < tlen) begin
            status = ST_SHORT;
        end else if (tlen == 3'd1) begin
            status = (par_next ^ (^hold_next[0])) ? ST_FAIL : ST_OK;
        end else if (tlen == 3'd4) begin
            status = (rx_crc == crc_next) ? ST_OK : ST_FAIL;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || frame_clear) begin
            phase_reg <= PH_IDLE;
            left_reg  <= 8'd0;
            fill_reg  <= 3'd0;
            crc_reg   <= 32'h0;
            par_reg   <= 1'b0;
        end else if (step_en) begin
            if (frame_done) begin
                phase_reg <= PH_IDLE;
                left_reg  <= 8'd0;
                fill_reg  <= 3'd0;
                crc_reg   <= 32'h0;
                par_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                fill_reg  <= fill_next;
                crc_reg   <= crc_next;
                par_reg   <= par_next;
            end
        end
    end

    // Hold contents beyond the fill count are never read, so they need no reset.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            hold_reg <= hold_next;
        end
    end

    assign res_valid          = out_valid | frame_done;
    assign res.payload_byte   = out_byte;
    assign res.payload_valid  = out_valid;
    assign res.frame_end      = frame_done;
    assign res.frame_status   = frame_done ? status : ST_OK;

endmodule

// ===== src/lfrc_out_stage.sv =====
// Result register of the frame receiver; it frees itself as soon as a word is taken.
// Depends on lfrc_pkg.
module lfrc_out_stage
    import lfrc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  logic    res_valid,
    input  result_t res,
    input  logic    m_ready,
    output logic    advance,
    output logic    m_valid,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = step_en && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== src/link_frame_receiver_checker.sv =====
// Link frame receiver: count or flag/escape deframing with parity or CRC-32 trailer check.
// An accepted word waits in the input register; its result is registered at the output.
// Throughput: one word per cycle unless the output stalls; CRC runs between two registers.
// Words that cause no result are absorbed without using the result register.
// Reset (synchronous, active low) restores the default registers and an idle receiver.
// Depends on lfrc_pkg, lfrc_cfg_regs, lfrc_deframer, lfrc_out_stage, assert_macros.svh.
`include "assert_macros.svh"
module link_frame_receiver_checker
    import lfrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_payload_valid,
    output logic       m_frame_end,
    output logic [1:0] m_frame_status,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_index,
    input  logic [7:0] cfg_wr_data
);

    cfg_t       cfg;
    logic       frame_clear;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       step_en;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    lfrc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (cfg_wr_en),
        .wr_index    (cfg_wr_index),
        .wr_data     (cfg_wr_data),
        .cfg         (cfg),
        .frame_clear (frame_clear)
    );

    // The input word moves on whenever the result register can take its outcome.
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    lfrc_deframer u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .frame_clear (frame_clear),
        .step_en     (step_en),
        .rx_byte     (in_byte_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    lfrc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_res     (m_res)
    );

    assign m_payload_byte  = m_res.payload_byte;
    assign m_payload_valid = m_res.payload_valid;
    assign m_frame_end     = m_res.frame_end;
    assign m_frame_status  = m_res.frame_status;

    `LFRC_ASSERT_IMPLIES(a_result_not_empty, m_valid, m_payload_valid || m_frame_end)
    `LFRC_ASSERT_IMPLIES(a_status_only_at_end, m_valid && !m_frame_end, m_frame_status == ST_OK)
    `LFRC_ASSERT_IMPLIES(a_byte_zero_when_empty, m_valid && !m_payload_valid,
                         m_payload_byte == 8'd0)
    `LFRC_ASSERT_IMPLIES(a_status_code_legal, m_valid, m_frame_status != 2'd3)

endmodule
